>>> design/sfw_pkg.sv
package sfw_pkg;

  // Item opcodes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_UPDATE    = 2'd0;
  localparam logic [1:0] KIND_FAULT     = 2'd1;
  localparam logic [1:0] KIND_BROADCAST = 2'd2;

  // Update answer codes.
  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_OUT_OF_RANGE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLED        = 2'd0;
  localparam logic [1:0] REG_WATCHDOG_PER   = 2'd1;
  localparam logic [1:0] REG_BROADCAST_PER  = 2'd2;

  // Register reset values.
  localparam logic [15:0] WATCHDOG_PER_RST  = 16'd1000;
  localparam logic [15:0] BROADCAST_PER_RST = 16'd100;

  // Depths of the command queue and the result queue.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // Classified command word passed from the front to the executor.
  typedef struct packed {
    logic        op;
    logic        src_ok;
    logic [2:0]  src;
    logic [15:0] value;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [15:0] bval;
    logic        last;
  } rslt_t;

endpackage

>>> design/sfw_front.sv
module sfw_front import sfw_pkg::*; #(
  parameter int NUM_SOURCES = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [2:0]        source,
  input  logic signed [15:0] value,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output cmd_t              cmd
);

  localparam logic [3:0] NUM_SRC_W = 4'(NUM_SOURCES);

  cmd_t       mem [CMD_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  cmd_t       cmd_in;

  // Classify the incoming word: opcode and source range check.
  always_comb begin
    cmd_in.op     = op;
    cmd_in.src_ok = ({1'b0, source} < NUM_SRC_W);
    cmd_in.src    = source;
    cmd_in.value  = $unsigned(value);
  end

  assign accept    = push && !full;
  assign full      = (count == 2'(CMD_DEPTH));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = mem[rd_ptr];

  // Command storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(cmd_take);
    end
  end

  // A taken command must exist.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("command taken from an empty queue");

  // The fill count never goes past the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(CMD_DEPTH)) else $error("command queue overflow");

endmodule

>>> design/sfw_exec.sv
module sfw_exec import sfw_pkg::*; #(
  parameter int NUM_SOURCES   = 2,
  parameter int CRUISE_SOURCE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  cmd_t        cmd,
  input  logic        res_room,
  output logic [1:0]  res_n,
  output rslt_t       res0,
  output rslt_t       res1
);

  localparam logic [NUM_SOURCES-1:0] ALL_SEEN = {NUM_SOURCES{1'b1}};

  logic                   enabled;
  logic [15:0]            wd_period;
  logic [15:0]            bc_period;
  logic [15:0]            values [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] seen_mask;
  logic [15:0]            wd_count;
  logic [15:0]            bc_count;

  logic [16:0]            wd_inc;
  logic [16:0]            bc_inc;
  logic [16:0]            wd_lim;
  logic [16:0]            bc_lim;
  logic                   wd_hit;
  logic                   bc_hit;
  logic [15:0]            wd_count_next;
  logic [15:0]            bc_count_next;
  logic                   tick_run;
  logic                   fault;
  logic [15:0]            cruise_val;
  logic                   cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cmd_take  = cmd_valid && res_room && !cfg_we;
  assign tick_run  = (cmd.op == OP_TICK) && enabled;

  // Period counters; a zero period behaves as one.
  always_comb begin
    wd_inc = {1'b0, wd_count} + 17'd1;
    bc_inc = {1'b0, bc_count} + 17'd1;
    wd_lim = {1'b0, (wd_period == 16'd0) ? 16'd1 : wd_period};
    bc_lim = {1'b0, (bc_period == 16'd0) ? 16'd1 : bc_period};
    wd_hit = (wd_inc >= wd_lim);
    bc_hit = (bc_inc >= bc_lim);
    wd_count_next = wd_hit ? 16'd0 : wd_inc[15:0];
    bc_count_next = bc_hit ? 16'd0 : bc_inc[15:0];
    fault = wd_hit && (seen_mask != ALL_SEEN);
  end

  // Cruise sample; zero when the cruise source is not implemented.
  always_comb begin
    cruise_val = 16'd0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (i == CRUISE_SOURCE) begin
        cruise_val = values[i];
      end
    end
  end

  // Result words caused by the current command.
  always_comb begin
    res_n = 2'd0;
    res0  = '0;
    res1  = '0;
    if (cmd_take) begin
      if (cmd.op == OP_UPDATE) begin
        res_n       = 2'd1;
        res0.kind   = KIND_UPDATE;
        res0.status = cmd.src_ok ? STATUS_OK : STATUS_OUT_OF_RANGE;
        res0.last   = 1'b1;
      end else if (tick_run) begin
        if (fault) begin
          res_n      = 2'd1;
          res0.kind  = KIND_FAULT;
          res0.last  = !bc_hit;
          if (bc_hit) begin
            // The fault has cleared the samples, so the broadcast carries zero.
            res_n     = 2'd2;
            res1.kind = KIND_BROADCAST;
            res1.bval = 16'd0;
            res1.last = 1'b1;
          end
        end else if (bc_hit) begin
          res_n     = 2'd1;
          res0.kind = KIND_BROADCAST;
          res0.bval = cruise_val;
          res0.last = 1'b1;
        end
      end
    end
  end

  // Configuration registers, counters, mask and stored samples.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b0;
      wd_period <= WATCHDOG_PER_RST;
      bc_period <= BROADCAST_PER_RST;
      seen_mask <= '0;
      wd_count  <= 16'd0;
      bc_count  <= 16'd0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        values[i] <= 16'd0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED: begin
          enabled  <= cfg_data[0];
          wd_count <= 16'd0;
          bc_count <= 16'd0;
          if (cfg_data[0]) begin
            seen_mask <= '0;
          end
        end
        REG_WATCHDOG_PER:  wd_period <= cfg_data;
        REG_BROADCAST_PER: bc_period <= cfg_data;
        default: ;
      endcase
    end else if (cmd_take) begin
      if (cmd.op == OP_UPDATE) begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (cmd.src == 3'(i)) begin
            values[i]    <= cmd.value;
            seen_mask[i] <= 1'b1;
          end
        end
      end else if (tick_run) begin
        wd_count <= wd_count_next;
        bc_count <= bc_count_next;
        if (wd_hit) begin
          seen_mask <= '0;
        end
        if (fault) begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            values[i] <= 16'd0;
          end
        end
      end
    end
  end

  // Two result words only come from a tick with both a fault and a broadcast.
  a_two_results: assert property (@(posedge clk) disable iff (rst)
    (res_n == 2'd2) |-> (cmd.op == OP_TICK && fault && bc_hit))
    else $error("double result without fault and broadcast");

  // A disabled block leaves its counters alone on a tick.
  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.op == OP_TICK && !enabled) |=>
      ($stable(wd_count) && $stable(bc_count)))
    else $error("counter moved while disabled");

endmodule

>>> design/sfw_rfifo.sv
module sfw_rfifo import sfw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_n,
  input  rslt_t      wr0,
  input  rslt_t      wr1,
  output logic       room,
  output logic       empty,
  input  logic       pop,
  output rslt_t      head
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  rslt_t         mem [RES_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          rd_en;

  // Room means two more words fit.
  assign room  = (count <= CW'(RES_DEPTH - 2));
  assign empty = (count == '0);
  assign rd_en = pop && !empty;
  assign head  = mem[rd_ptr];

  // Result storage, up to two writes per cycle.
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= wr1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(wr_n);
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(wr_n) - CW'(rd_en);
    end
  end

  // Words are only written when there is room for them.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr_n != 2'd0) |-> room) else $error("result queue overflow");

  // A popped word leaves the count one lower unless new words arrive.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_n == 2'd0) |=> (count == $past(count) - CW'(1)))
    else $error("result count mismatch on pop");

endmodule

>>> design/source_freshness_watchdog_core.sv
// Source freshness watchdog.
// Input channel: present op, source and value with push; the word is taken on
// a clock edge where push is high and full is low. An update stores the sample
// and answers with kind 0; a tick advances the watchdog and broadcast counters
// while enabled and may yield a fault word, a broadcast word, or both.
// Result channel: while empty is low the oldest result is on kind, status,
// broadcast_value and last; it is taken on an edge where pop is high.
// Configuration: cfg_valid, cfg_index, cfg_data with cfg_ready always high;
// write only while no items are in flight.
// Result path: an accepted item waits in the command queue; the executor
// takes it while the result queue has room and writes its results into the
// result queue at that same edge, from where they reach the result ports.
// Throughput: one item per cycle through the two-entry command queue while
// the result queue has room and no register write is taken; a tick that
// gives two results needs two pops. When the receiver stalls, the four-entry
// result queue fills, the executor waits until two entries are free, and full
// rises once the command queue holds two words.
// Reset clears both queues, the counters, the mask and the samples, and
// loads enabled 0, watchdog period 1000 and broadcast period 100.
module source_freshness_watchdog_core import sfw_pkg::*; #(
  parameter int NUM_SOURCES   = 2,
  parameter int CRUISE_SOURCE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic [2:0]         source,
  input  logic signed [15:0] value,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic               status,
  output logic [15:0]        broadcast_value,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic       cmd_valid;
  logic       cmd_take;
  cmd_t       cmd;
  logic       res_room;
  logic [1:0] res_n;
  rslt_t      res0;
  rslt_t      res1;
  rslt_t      head;

  // Front: accepts and classifies input words.
  sfw_front #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .source   (source),
    .value    (value),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  // Executor: state, counters and result generation.
  sfw_exec #(
    .NUM_SOURCES  (NUM_SOURCES),
    .CRUISE_SOURCE(CRUISE_SOURCE)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd),
    .res_room (res_room),
    .res_n    (res_n),
    .res0     (res0),
    .res1     (res1)
  );

  // Result queue toward the receiver.
  sfw_rfifo u_rfifo (
    .clk  (clk),
    .rst  (rst),
    .wr_n (res_n),
    .wr0  (res0),
    .wr1  (res1),
    .room (res_room),
    .empty(empty),
    .pop  (pop),
    .head (head)
  );

  assign kind            = head.kind;
  assign status          = head.status;
  assign broadcast_value = head.bval;
  assign last            = head.last;

endmodule

>>> test/sfw_checker.sv
// Watches the input, configuration and result channels of the freshness
// watchdog and predicts every result word from its own copy of the state.
module sfw_checker import sfw_pkg::*; #(
  parameter int NUM_SOURCES   = 2,
  parameter int CRUISE_SOURCE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        op,
  input  logic [2:0]  source,
  input  logic [15:0] value,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  kind,
  input  logic        status,
  input  logic [15:0] broadcast_value,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          words_due
);

  // Mirror of the block's registers and state.
  logic                   en;
  logic [15:0]            wd_period;
  logic [15:0]            bc_period;
  logic [15:0]            samples [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] seen;
  logic [15:0]            wd_count;
  logic [15:0]            bc_count;

  // Result words predicted but not yet popped, oldest first.
  rslt_t due_words[$];
  int    fails = 0;
  int    due_n = 0;

  assign fail_count = fails;
  assign words_due  = due_n;

  // Advances a period counter by one tick. The top bit tells that the period
  // expired; a period of zero behaves as a period of one.
  function automatic logic [16:0] count_step(logic [15:0] cnt, logic [15:0] period);
    logic [16:0] nxt;
    logic [16:0] lim;
    nxt = {1'b0, cnt} + 17'd1;
    lim = (period == 16'd0) ? 17'd1 : {1'b0, period};
    if (nxt >= lim) return {1'b1, 16'd0};
    return {1'b0, nxt[15:0]};
  endfunction

  task automatic clear_samples();
    foreach (samples[i]) samples[i] = 16'd0;
  endtask

  // Applies one register write.
  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    if (idx == REG_ENABLED) begin
      en       = data[0];
      wd_count = 16'd0;
      bc_count = 16'd0;
      if (data[0]) seen = '0;
    end else if (idx == REG_WATCHDOG_PER) begin
      wd_period = data;
    end else if (idx == REG_BROADCAST_PER) begin
      bc_period = data;
    end
  endtask

  // Updates the state for one accepted word and queues the words it causes.
  task automatic track_item(logic it_op, logic [2:0] it_src, logic [15:0] it_val);
    logic [16:0] wd_next;
    logic [16:0] bc_next;
    logic        fault;
    rslt_t       w;
    w = '0;
    if (it_op == OP_UPDATE) begin
      w.kind   = KIND_UPDATE;
      w.status = STATUS_OUT_OF_RANGE;
      w.last   = 1'b1;
      // Only an implemented source stores its sample and marks itself seen.
      foreach (samples[i]) begin
        if (it_src == 3'(i)) begin
          samples[i] = it_val;
          seen[i]    = 1'b1;
          w.status   = STATUS_OK;
        end
      end
      due_words.push_back(w);
    end else if (en) begin
      wd_next  = count_step(wd_count, wd_period);
      bc_next  = count_step(bc_count, bc_period);
      wd_count = wd_next[15:0];
      bc_count = bc_next[15:0];
      fault    = 1'b0;
      if (wd_next[16]) begin
        if (seen != '1) begin
          clear_samples();
          fault = 1'b1;
        end
        seen = '0;
      end
      // The fault word always comes ahead of the broadcast on the same tick.
      if (fault) begin
        w.kind = KIND_FAULT;
        w.last = !bc_next[16];
        due_words.push_back(w);
      end
      if (bc_next[16]) begin
        w      = '0;
        w.kind = KIND_BROADCAST;
        w.last = 1'b1;
        foreach (samples[i]) begin
          if (i == CRUISE_SOURCE) w.bval = samples[i];
        end
        due_words.push_back(w);
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Register writes and items never share an edge, so the order below only
  // matters for the result side, which is compared after the prediction.
  always @(posedge clk) begin
    rslt_t want;
    if (rst) begin
      en        = 1'b0;
      wd_period = WATCHDOG_PER_RST;
      bc_period = BROADCAST_PER_RST;
      clear_samples();
      seen      = '0;
      wd_count  = 16'd0;
      bc_count  = 16'd0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (push && !full) track_item(op, source, value);
      if (pop && !empty) begin
        if (due_words.size() == 0) begin
          $error("result word with none expected: kind %0d", kind);
          fails++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", want.kind, kind);
          check_field("status", want.status, status);
          check_field("broadcast_value", want.bval, broadcast_value);
          check_field("last", want.last, last);
        end
      end
    end
    due_n = due_words.size();
  end

endmodule

>>> test/source_freshness_watchdog_core_tb.sv
// Drives updates, ticks and register writes into the freshness watchdog with
// random gaps and random result stalls; the checker does all comparing.
module source_freshness_watchdog_core_tb;
  import sfw_pkg::*;

  localparam int N_SRC  = 2;
  localparam int CRUISE = 0;
  // The one register index with no register behind it.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1900;
  // Cycles that let a word with no result leave the pipeline.
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        op = OP_UPDATE;
  logic [2:0]  source = 3'd0;
  logic [15:0] value = 16'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic        status;
  logic [15:0] broadcast_value;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_ENABLED;
  logic [15:0] cfg_data = 16'd0;
  int          fail_count;
  int          words_due;

  int   sent = 0;
  logic burst = 1'b0;

  source_freshness_watchdog_core #(
    .NUM_SOURCES  (N_SRC),
    .CRUISE_SOURCE(CRUISE)
  ) u_top (
    .clk, .rst, .push, .full, .op, .source, .value, .empty, .pop, .kind,
    .status, .broadcast_value, .last, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data
  );

  sfw_checker #(
    .NUM_SOURCES  (N_SRC),
    .CRUISE_SOURCE(CRUISE)
  ) u_checker (
    .clk, .rst, .push, .full, .op, .source, .value, .empty, .pop, .kind,
    .status, .broadcast_value, .last, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .fail_count, .words_due
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

  // Mostly back to back, sometimes a few idle cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 30);
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 30) return 16'($urandom_range(50, 400));
    return 16'($urandom_range(1, 8));
  endfunction

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    if (r < 25) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is
  // taken, with push still high so that the next word may follow at once.
  task automatic send_word(logic o, logic [2:0] s, logic [15:0] v);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push   <= 1'b1;
    op     <= o;
    source <= s;
    value  <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
  endtask

  // Registers are written only once every word has left the block.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    push <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The result side pops at random, with short and long stalls and with
  // stretches of popping on every cycle.
  initial begin
    int stall_left;
    int free_left;
    int r;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) free_left = $urandom_range(30, 150);
          else if (r < 23) stall_left = $urandom_range(1, 3);
          else if (r < 27) stall_left = $urandom_range(4, 12);
          else if (r < 28) stall_left = $urandom_range(20, 30);
        end
      end
    end
  end

  initial begin
    int upd_pct;
    int oor_pct;
    int n;
    logic [2:0] src;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Updates at the value extremes and out of range while still disabled;
    // ticks change nothing yet.
    send_word(OP_UPDATE, 3'd0, 16'h8000);
    send_word(OP_UPDATE, 3'd1, 16'h7FFF);
    send_word(OP_UPDATE, 3'd2, 16'h0001);
    send_word(OP_UPDATE, 3'd7, 16'hFFFF);
    send_tick();
    send_tick();

    // An unknown index is ignored; zero watchdog period expires every tick.
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_WATCHDOG_PER, 16'd0);
    write_reg(REG_BROADCAST_PER, 16'd1);
    write_reg(REG_ENABLED, 16'd1);
    send_tick();
    send_word(OP_UPDATE, 3'd0, 16'hFFFF);
    send_word(OP_UPDATE, 3'd1, 16'h0000);
    send_tick();
    send_tick();

    // Shortening a period below the running count expires it on the next tick.
    write_reg(REG_WATCHDOG_PER, 16'hFFFF);
    write_reg(REG_BROADCAST_PER, 16'hFFFF);
    send_word(OP_UPDATE, 3'd0, 16'h1234);
    repeat (4) send_tick();
    write_reg(REG_BROADCAST_PER, 16'd3);
    send_tick();
    write_reg(REG_WATCHDOG_PER, 16'd2);
    send_tick();

    // Disabling keeps the mask and stores updates; enabling clears the mask.
    write_reg(REG_ENABLED, 16'd0);
    send_word(OP_UPDATE, 3'd1, 16'h00FF);
    send_tick();
    write_reg(REG_ENABLED, 16'd1);
    send_word(OP_UPDATE, 3'd0, 16'h0F0F);
    send_tick();
    send_tick();

    // Random phases, each with its own settings and traffic mix.
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) write_reg(REG_SPARE, 16'($urandom));
      if ($urandom_range(0, 99) < 80) write_reg(REG_WATCHDOG_PER, pick_period());
      if ($urandom_range(0, 99) < 80) write_reg(REG_BROADCAST_PER, pick_period());
      if ($urandom_range(0, 99) < 70) begin
        write_reg(REG_ENABLED, {15'd0, $urandom_range(0, 9) != 0});
      end
      burst   = ($urandom_range(0, 4) == 0);
      upd_pct = $urandom_range(10, 80);
      oor_pct = $urandom_range(0, 30);
      n       = $urandom_range(20, 100);
      repeat (n) begin
        if ($urandom_range(0, 99) < upd_pct) begin
          if ($urandom_range(0, 99) < oor_pct) src = 3'($urandom_range(N_SRC, 7));
          else src = 3'($urandom_range(0, N_SRC - 1));
          send_word(OP_UPDATE, src, pick_sample());
        end else begin
          send_tick();
        end
      end
    end

    // Let every expected word come out, then a few more cycles for strays.
    push <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
